### rtl/rne_pkg.sv
package rne_pkg;

  localparam int unsigned LEN_W  = 7;
  localparam int unsigned REM_W  = 16;
  localparam int unsigned DIG_W  = 4;
  localparam int unsigned PLEN_W = 3;
  localparam int unsigned PC_W   = 4;
  localparam int unsigned NROWS  = 3;

  typedef logic [PC_W-1:0]   pc_t;
  typedef logic [1:0]        row_t;
  typedef logic [DIG_W-1:0]  digit_t;
  typedef logic [PLEN_W-1:0] plen_t;

  localparam logic [REM_W-1:0] THOUSAND = REM_W'(1000);
  localparam logic [7:0]       CHAR_M   = 8'h4D;

  typedef enum logic [2:0] {
    OP_ACCEPT,
    OP_DIV,
    OP_ROW,
    OP_EMIT_M,
    OP_EMIT_PIECE,
    OP_FIN
  } op_e;

  // Symbol classes inside one decimal place: unit, five, next unit up.
  typedef enum logic [1:0] {
    SYM_ONE,
    SYM_FIVE,
    SYM_TEN
  } sym_e;

  typedef struct packed {
    op_e  op;
    row_t row;
    pc_t  jmp;
  } uword_t;

  typedef struct packed {
    digit_t           digit;
    logic [REM_W-1:0] rem;
    plen_t            plen;
  } rne_digit_t;

  localparam pc_t PC_ACCEPT = 4'd0;
  localparam pc_t PC_EMIT_M = 4'd5;
  localparam pc_t PC_FIN    = 4'd9;

  // Microprogram: one control word per step.
  function automatic uword_t rne_ucode(pc_t pc);
    uword_t w;
    case (pc)
      4'd0:    w = '{op: OP_ACCEPT,     row: 2'd0, jmp: PC_FIN};
      4'd1:    w = '{op: OP_DIV,        row: 2'd0, jmp: PC_ACCEPT};
      4'd2:    w = '{op: OP_ROW,        row: 2'd0, jmp: PC_ACCEPT};
      4'd3:    w = '{op: OP_ROW,        row: 2'd1, jmp: PC_ACCEPT};
      4'd4:    w = '{op: OP_ROW,        row: 2'd2, jmp: PC_ACCEPT};
      4'd5:    w = '{op: OP_EMIT_M,     row: 2'd0, jmp: PC_ACCEPT};
      4'd6:    w = '{op: OP_EMIT_PIECE, row: 2'd0, jmp: PC_ACCEPT};
      4'd7:    w = '{op: OP_EMIT_PIECE, row: 2'd1, jmp: PC_ACCEPT};
      4'd8:    w = '{op: OP_EMIT_PIECE, row: 2'd2, jmp: PC_ACCEPT};
      4'd9:    w = '{op: OP_FIN,        row: 2'd0, jmp: PC_ACCEPT};
      default: w = '{op: OP_FIN,        row: 2'd0, jmp: PC_ACCEPT};
    endcase
    return w;
  endfunction

  function automatic plen_t rne_plen(digit_t d);
    plen_t n;
    case (d)
      4'd1, 4'd5:                n = 3'd1;
      4'd2, 4'd4, 4'd6, 4'd9:    n = 3'd2;
      4'd3, 4'd7:                n = 3'd3;
      4'd8:                      n = 3'd4;
      default:                   n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic sym_e rne_sym(digit_t d, logic [1:0] k);
    sym_e s;
    case (d)
      4'd4:                s = (k == 2'd0) ? SYM_ONE : SYM_FIVE;
      4'd5:                s = SYM_FIVE;
      4'd6, 4'd7, 4'd8:    s = (k == 2'd0) ? SYM_FIVE : SYM_ONE;
      4'd9:                s = (k == 2'd0) ? SYM_ONE : SYM_TEN;
      default:             s = SYM_ONE;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] rne_letter(row_t r, sym_e s);
    logic [7:0] c;
    case (r)
      2'd0: begin
        case (s)
          SYM_ONE:  c = 8'h43; // C
          SYM_FIVE: c = 8'h44; // D
          default:  c = 8'h4D; // M
        endcase
      end
      2'd1: begin
        case (s)
          SYM_ONE:  c = 8'h58; // X
          SYM_FIVE: c = 8'h4C; // L
          default:  c = 8'h43; // C
        endcase
      end
      default: begin
        case (s)
          SYM_ONE:  c = 8'h49; // I
          SYM_FIVE: c = 8'h56; // V
          default:  c = 8'h58; // X
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

### rtl/rne_digit.sv
module rne_digit (
  input  logic [rne_pkg::REM_W-1:0] rem_i,
  input  rne_pkg::row_t             row_i,
  output rne_pkg::rne_digit_t       res_o
);
  import rne_pkg::*;

  logic [REM_W-1:0] unit;
  digit_t           d;

  always_comb begin
    case (row_i)
      2'd0:    unit = REM_W'(100);
      2'd1:    unit = REM_W'(10);
      default: unit = REM_W'(1);
    endcase
  end

  // Highest multiple of the place unit that still fits the remainder.
  always_comb begin
    d = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_i >= REM_W'(k) * unit) begin
        d = DIG_W'(k);
      end
    end
  end

  assign res_o.digit = d;
  assign res_o.rem   = rem_i - REM_W'(d) * unit;
  assign res_o.plen  = rne_plen(d);

endmodule

### rtl/roman_numeral_encoder_top.sv
// Converts one 64-bit unsigned value per transfer into its Roman numeral, one ASCII letter
// per output transfer, the final one flagged last with the length and overflow status.
// A small microprogram sequences the work: the thousands run is found by subtracting 1000
// once per cycle, then one step per decimal place picks its piece, then letters leave at
// one per cycle while the output is not stalled. A value with no letters sends a single
// empty transfer flagged last; a value whose thousands run does not fit the buffer skips
// straight to that transfer, flagged overflow.
// A new value is taken only once the previous one has been fully sequenced; the last
// letter may still wait in the output register.
module roman_numeral_encoder_top #(
  parameter int unsigned MAX_LENGTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rne_pkg::LEN_W-1:0] cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [63:0]               value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      char_valid_o,
  output logic [7:0]                char_code_o,
  output logic                      last_o,
  output logic                      overflow_o,
  output logic [rne_pkg::LEN_W-1:0] length_o
);
  import rne_pkg::*;

  localparam int unsigned LIM_W = 17;

  logic [LEN_W-1:0] buf_q;
  pc_t              pc_q, pc_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] cap_q, cap_d;
  logic [LEN_W-1:0] thou_q, thou_d;
  logic [LEN_W-1:0] used_q, used_d;
  logic [LEN_W-1:0] cnt_q, cnt_d;
  logic [LEN_W-1:0] emit_q, emit_d;
  logic             ovf_q, ovf_d;
  digit_t           dig_q [NROWS];
  digit_t           dig_d [NROWS];
  logic [NROWS-1:0] keep_q, keep_d;

  logic             out_valid_q, out_valid_d;
  logic             out_cv_q, out_cv_d;
  logic [7:0]       out_char_q, out_char_d;
  logic             out_last_q, out_last_d;
  logic             out_ovf_q, out_ovf_d;
  logic [LEN_W-1:0] out_len_q, out_len_d;

  uword_t           uw;
  rne_digit_t       dres;
  logic [LEN_W-1:0] cap_w;
  logic [LIM_W-1:0] lim;
  logic             big;
  logic             slot_free;
  logic             accept_in;
  logic             adv, take;
  logic             emit, emit_cv;
  logic [7:0]       emit_char;
  plen_t            plen_sel;

  assign uw         = rne_ucode(pc_q);
  assign in_stall_o = (pc_q != PC_ACCEPT);
  assign accept_in  = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  assign cap_w = (buf_q > LEN_W'(MAX_LENGTH)) ? LEN_W'(MAX_LENGTH) : buf_q;
  assign lim   = (LIM_W'(cap_w) + LIM_W'(1)) * LIM_W'(1000);
  // Thousands run longer than the buffer: overflow with nothing written.
  assign big   = (|value_i[63:LIM_W]) || (value_i[LIM_W-1:0] >= lim);

  rne_digit u_digit (
    .rem_i (rem_q),
    .row_i (uw.row),
    .res_o (dres)
  );

  assign plen_sel = rne_plen(dig_q[uw.row]);

  always_comb begin
    adv       = 1'b0;
    take      = 1'b0;
    emit      = 1'b0;
    emit_cv   = 1'b0;
    emit_char = '0;
    rem_d     = rem_q;
    cap_d     = cap_q;
    thou_d    = thou_q;
    used_d    = used_q;
    cnt_d     = cnt_q;
    emit_d    = emit_q;
    ovf_d     = ovf_q;
    dig_d     = dig_q;
    keep_d    = keep_q;

    case (uw.op)
      OP_ACCEPT: begin
        if (accept_in) begin
          cap_d  = cap_w;
          rem_d  = value_i[REM_W-1:0];
          thou_d = '0;
          used_d = '0;
          cnt_d  = '0;
          emit_d = '0;
          keep_d = '0;
          ovf_d  = big;
          if (big) begin
            take = 1'b1;
          end else begin
            adv = 1'b1;
          end
        end
      end
      OP_DIV: begin
        if (rem_q >= THOUSAND) begin
          rem_d  = rem_q - THOUSAND;
          thou_d = thou_q + LEN_W'(1);
          used_d = used_q + LEN_W'(1);
        end else begin
          adv = 1'b1;
        end
      end
      OP_ROW: begin
        dig_d[uw.row] = dres.digit;
        rem_d         = dres.rem;
        if (!ovf_q && (dres.digit != '0)) begin
          if (used_q + LEN_W'(dres.plen) > cap_q) begin
            ovf_d = 1'b1;
          end else begin
            used_d         = used_q + LEN_W'(dres.plen);
            keep_d[uw.row] = 1'b1;
          end
        end
        adv = 1'b1;
      end
      OP_EMIT_M: begin
        if (cnt_q == thou_q) begin
          cnt_d = '0;
          adv   = 1'b1;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_cv   = 1'b1;
          emit_char = CHAR_M;
          cnt_d     = cnt_q + LEN_W'(1);
          emit_d    = emit_q + LEN_W'(1);
        end
      end
      OP_EMIT_PIECE: begin
        if (!keep_q[uw.row]) begin
          adv = 1'b1;
        end else if (slot_free) begin
          emit      = 1'b1;
          emit_cv   = 1'b1;
          emit_char = rne_letter(uw.row, rne_sym(dig_q[uw.row], cnt_q[1:0]));
          emit_d    = emit_q + LEN_W'(1);
          if (cnt_q == LEN_W'(plen_sel) - LEN_W'(1)) begin
            cnt_d = '0;
            adv   = 1'b1;
          end else begin
            cnt_d = cnt_q + LEN_W'(1);
          end
        end
      end
      OP_FIN: begin
        // No letters: send one empty closing transfer.
        if (used_q == '0) begin
          if (slot_free) begin
            emit = 1'b1;
            take = 1'b1;
          end
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        take = 1'b1;
      end
    endcase
  end

  always_comb begin
    if (take) begin
      pc_d = uw.jmp;
    end else if (adv) begin
      pc_d = pc_q + PC_W'(1);
    end else begin
      pc_d = pc_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_cv_d    = out_cv_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    out_len_d   = out_len_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_cv_d    = emit_cv;
      out_char_d  = emit_char;
      out_last_d  = emit_cv ? (emit_q + LEN_W'(1) == used_q) : 1'b1;
      out_ovf_d   = out_last_d && ovf_q;
      out_len_d   = out_last_d ? used_q : '0;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q       <= LEN_W'(64);
      pc_q        <= PC_ACCEPT;
      rem_q       <= '0;
      cap_q       <= '0;
      thou_q      <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      emit_q      <= '0;
      ovf_q       <= 1'b0;
      keep_q      <= '0;
      for (int i = 0; i < NROWS; i++) begin
        dig_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      out_cv_q    <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
      out_len_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        buf_q <= cfg_wdata_i;
      end
      pc_q        <= pc_d;
      rem_q       <= rem_d;
      cap_q       <= cap_d;
      thou_q      <= thou_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      emit_q      <= emit_d;
      ovf_q       <= ovf_d;
      keep_q      <= keep_d;
      dig_q       <= dig_d;
      out_valid_q <= out_valid_d;
      out_cv_q    <= out_cv_d;
      out_char_q  <= out_char_d;
      out_last_q  <= out_last_d;
      out_ovf_q   <= out_ovf_d;
      out_len_q   <= out_len_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_valid_o = out_cv_q;
  assign char_code_o  = out_char_q;
  assign last_o       = out_last_q;
  assign overflow_o   = out_ovf_q;
  assign length_o     = out_len_q;

  a_emit_within_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_q <= used_q)
    else $error("more letters sent than planned");

  a_thou_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    thou_q <= cap_q)
    else $error("thousands run exceeds capacity");

  a_m_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == PC_EMIT_M) |-> (cnt_q <= thou_q))
    else $error("M run counter past thousands count");

  a_ovf_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && overflow_o) |-> last_o)
    else $error("overflow flagged on a non-final transfer");

  a_mid_has_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> char_valid_o)
    else $error("empty transfer before the final one");

endmodule

### tb/sv/roman_numeral_encoder_top_tb.sv
module roman_numeral_encoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rne_pkg::*;

  localparam int unsigned MAX_LEN     = 64;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 400;
  localparam int unsigned HOLD_AFTER  = 40;

  localparam logic [7:0] LETTER_I = 8'h49;
  localparam logic [7:0] LETTER_V = 8'h56;
  localparam logic [7:0] LETTER_X = 8'h58;
  localparam logic [7:0] LETTER_L = 8'h4C;
  localparam logic [7:0] LETTER_C = 8'h43;
  localparam logic [7:0] LETTER_D = 8'h44;
  localparam logic [7:0] LETTER_M = 8'h4D;

  typedef struct packed {
    logic             char_valid;
    logic [7:0]       code;
    logic             last;
    logic             ovf;
    logic [LEN_W-1:0] len;
  } roman_letter_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             cfg_we_i    = 1'b0;
  logic [LEN_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic [63:0]      value_i     = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             char_valid_o;
  logic [7:0]       char_code_o;
  logic             last_o;
  logic             overflow_o;
  logic [LEN_W-1:0] length_o;

  logic [63:0]      pending_values[$];
  roman_letter_t    expected_letters[$];
  logic [LEN_W-1:0] buffer_len_shadow = LEN_W'(64);
  int unsigned      idle_pct        = 0;
  int unsigned      items_sent      = 0;
  int unsigned      mismatch_count  = 0;
  int unsigned      cycle_count     = 0;
  int unsigned      gap_left        = 0;
  int unsigned      stall_left      = 0;
  int unsigned      hold_left       = 0;
  bit               long_hold_done  = 1'b0;
  logic             valid_nxt;
  logic [63:0]      value_nxt;
  logic             stall_nxt;
  roman_letter_t    want;

  roman_numeral_encoder_top #(
    .MAX_LENGTH(MAX_LEN)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_valid_o(char_valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o),
    .overflow_o  (overflow_o),
    .length_o    (length_o)
  );

  // Expected letters of one conversion, queued in output order.
  function automatic void encode_roman(logic [63:0] value, logic [LEN_W-1:0] buf_len);
    logic [7:0]    text[$];
    logic [7:0]    piece[$];
    logic [63:0]   thousands;
    logic [7:0]    unit, five, ten;
    int unsigned   cap, rest, digit;
    bit            spilled;
    roman_letter_t e;
    cap = (buf_len > MAX_LEN) ? MAX_LEN : int'(buf_len);
    thousands = value / 64'd1000;
    rest = int'(value % 64'd1000);
    spilled = 1'b0;
    if (thousands > 64'(cap)) begin
      spilled = 1'b1;
    end else begin
      repeat (int'(thousands)) text.push_back(LETTER_M);
    end
    for (int place = 0; place < 3; place++) begin
      case (place)
        0: begin
          digit = rest / 100;
          unit = LETTER_C; five = LETTER_D; ten = LETTER_M;
        end
        1: begin
          digit = (rest / 10) % 10;
          unit = LETTER_X; five = LETTER_L; ten = LETTER_C;
        end
        default: begin
          digit = rest % 10;
          unit = LETTER_I; five = LETTER_V; ten = LETTER_X;
        end
      endcase
      if (!spilled && digit != 0) begin
        piece.delete();
        if (digit == 9) begin
          piece.push_back(unit);
          piece.push_back(ten);
        end else if (digit == 4) begin
          piece.push_back(unit);
          piece.push_back(five);
        end else begin
          if (digit >= 5) piece.push_back(five);
          repeat (digit % 5) piece.push_back(unit);
        end
        // drop the whole piece if it does not fit
        if (piece.size() > cap - text.size()) begin
          spilled = 1'b1;
        end else begin
          foreach (piece[k]) text.push_back(piece[k]);
        end
      end
    end
    if (text.size() == 0) begin
      e = '{char_valid: 1'b0, code: 8'h00, last: 1'b1, ovf: spilled, len: '0};
      expected_letters.push_back(e);
    end else begin
      foreach (text[i]) begin
        e.char_valid = 1'b1;
        e.code       = text[i];
        e.last       = (i == text.size() - 1);
        e.ovf        = e.last && spilled;
        e.len        = e.last ? LEN_W'(text.size()) : '0;
        expected_letters.push_back(e);
      end
    end
  endfunction

  function automatic logic [63:0] random_operand(logic [LEN_W-1:0] buf_len);
    logic [63:0] pick;
    int unsigned cap, near;
    cap = (buf_len > MAX_LEN) ? MAX_LEN : int'(buf_len);
    case ($urandom_range(9))
      0: pick = {$urandom, $urandom};
      1: begin
        // thousands run right around the capacity
        near = cap + $urandom_range(3);
        near = (near >= 2) ? near - 2 : 0;
        pick = 64'(near) * 64'd1000 + 64'($urandom_range(999));
      end
      2, 3: pick = 64'($urandom_range(3999));
      4: pick = 64'($urandom_range(99));
      5: pick = 64'($urandom_range(cap)) * 64'd1000 + 64'($urandom_range(999));
      6: pick = 64'($urandom_range(3)) * 64'd1000
              + 64'(100 * ($urandom_range(1) ? 8 : $urandom_range(9)))
              + 64'(10 * ($urandom_range(1) ? 8 : $urandom_range(9)))
              + 64'($urandom_range(1) ? 8 : $urandom_range(9));
      7: pick = -64'($urandom_range(5000));
      default: pick = 64'($urandom_range(50)) * 64'd1000 + 64'($urandom_range(999));
    endcase
    return pick;
  endfunction

  task automatic write_buffer_len(logic [LEN_W-1:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    buffer_len_shadow = v;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_values.size() != 0 || in_valid_i || expected_letters.size() != 0);
  endtask

  task automatic run_random(logic [LEN_W-1:0] buf_len, int unsigned count, int unsigned pct);
    write_buffer_len(buf_len);
    idle_pct = pct;
    repeat (count) pending_values.push_back(random_operand(buf_len));
    wait_drained();
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Input side: offer queued values, hold until transfer, idle in bursts.
  always @(posedge clk_i) begin
    valid_nxt = in_valid_i;
    value_nxt = value_i;
    if (in_valid_i && !in_stall_o) begin
      encode_roman(value_i, buffer_len_shadow);
      items_sent++;
      valid_nxt = 1'b0;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap_left = $urandom_range(18, 1);
    end
    if (!valid_nxt) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_values.size() != 0) begin
        valid_nxt = 1'b1;
        value_nxt = pending_values.pop_front();
      end
    end
    in_valid_i <= valid_nxt;
    value_i    <= value_nxt;
  end

  // Output side stall: one long hold-off once enough items are sent, random bursts otherwise.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      stall_nxt = 1'b1;
    end else if (!long_hold_done && items_sent >= HOLD_AFTER) begin
      long_hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      stall_nxt = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      stall_nxt = 1'b1;
    end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      stall_left = $urandom_range(18, 1) - 1;
      stall_nxt = 1'b1;
    end else begin
      stall_nxt = 1'b0;
    end
    out_stall_i <= stall_nxt;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (expected_letters.size() == 0) begin
        $error("unexpected transfer: char_code %0h last %0b", char_code_o, last_o);
        mismatch_count++;
      end else begin
        want = expected_letters.pop_front();
        if (char_valid_o !== want.char_valid) begin
          $error("char_valid: expected %0b, got %0b", want.char_valid, char_valid_o);
          mismatch_count++;
        end
        if (char_code_o !== want.code) begin
          $error("char_code: expected %0h, got %0h", want.code, char_code_o);
          mismatch_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          mismatch_count++;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, overflow_o);
          mismatch_count++;
        end
        if (length_o !== want.len) begin
          $error("length: expected %0d, got %0d", want.len, length_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed values at the reset buffer length of 64.
    idle_pct = 20;
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd4);
    pending_values.push_back(64'd5);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd40);
    pending_values.push_back(64'd49);
    pending_values.push_back(64'd90);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd400);
    pending_values.push_back(64'd500);
    pending_values.push_back(64'd900);
    pending_values.push_back(64'd888);
    pending_values.push_back(64'd1000);
    pending_values.push_back(64'd3888);
    pending_values.push_back(64'd3999);
    pending_values.push_back(64'd64000);
    pending_values.push_back(64'd64888);
    pending_values.push_back(64'd65000);
    pending_values.push_back(64'd60388);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FC18);
    wait_drained();

    // Long enough to overlap the output hold-off and back up the input.
    run_random(LEN_W'(64), 60, 30);
    write_buffer_len(LEN_W'(0));
    pending_values.push_back(64'd0);
    wait_drained();
    run_random(LEN_W'(0), 15, 25);
    run_random(LEN_W'(1), 20, 25);
    run_random(LEN_W'(127), 25, 50);
    run_random(LEN_W'(7), 25, 0);
    run_random(LEN_W'(100), 20, 35);
    run_random(LEN_W'(64), 40, 0);

    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### roman_numeral_encoder_top.f
rtl/rne_pkg.sv
rtl/rne_digit.sv
rtl/roman_numeral_encoder_top.sv
tb/sv/roman_numeral_encoder_top_tb.sv
